/* hdl/lmsd_pkg.sv */
package lmsd_pkg;

  // display geometry
  localparam int unsigned DIGITS  = 8;
  localparam int unsigned ROW_W   = 8;
  localparam int unsigned DIG_AW  = $clog2(DIGITS);

  // serial front end
  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned BITCNT_W  = $clog2(WORD_BITS + 1);

  // scan timing
  localparam int unsigned SLOT_W     = 20;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned TOTAL_W    = SLOT_W + 1;
  localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1000);

  // event kinds carried in the mode field
  typedef enum logic [1:0] {
    EV_CLOCK = 2'd0,
    EV_LOAD  = 2'd1,
    EV_TICK  = 2'd2
  } event_e;

  // register addresses in the top byte of a serial word
  localparam logic [7:0] ADDR_DIGIT_LO  = 8'h01;
  localparam logic [7:0] ADDR_DIGIT_HI  = 8'(DIGITS);
  localparam logic [7:0] ADDR_DECODE    = 8'h09;
  localparam logic [7:0] ADDR_INTENSITY = 8'h0A;
  localparam logic [7:0] ADDR_SCAN_LIM  = 8'h0B;
  localparam logic [7:0] ADDR_SHUTDOWN  = 8'h0C;
  localparam logic [7:0] ADDR_TEST      = 8'h0F;

  // control registers seen by the scan / output logic
  typedef struct packed {
    logic [7:0]        decode;
    logic [3:0]        intensity;
    logic [DIG_AW-1:0] last_digit;
    logic              shutdown;
    logic              test;
  } disp_cfg_t;

endpackage

/* hdl/lmsd_in_if.sv */
interface lmsd_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        mode;
  logic                              pin_level;
  logic                              data_bit;
  logic [lmsd_pkg::ELAPSED_W-1:0]    elapsed_cycles;
  logic [lmsd_pkg::DIG_AW-1:0]       query_row;

  modport source (
    output valid, mode, pin_level, data_bit, elapsed_cycles, query_row,
    input  ready
  );
  modport sink (
    input  valid, mode, pin_level, data_bit, elapsed_cycles, query_row,
    output ready
  );
endinterface

/* hdl/lmsd_out_if.sv */
interface lmsd_out_if;
  logic                          valid;
  logic                          ready;
  logic [lmsd_pkg::ROW_W-1:0]    segment_drive;
  logic [lmsd_pkg::DIGITS-1:0]   digit_select;
  logic [lmsd_pkg::DIG_AW-1:0]   scan_position;
  logic [lmsd_pkg::ROW_W-1:0]    queried_pattern;
  logic                          register_written;
  logic [3:0]                    brightness;
  logic [7:0]                    decode_setting;

  modport source (
    output valid, segment_drive, digit_select, scan_position, queried_pattern,
           register_written, brightness, decode_setting,
    input  ready
  );
  modport sink (
    input  valid, segment_drive, digit_select, scan_position, queried_pattern,
           register_written, brightness, decode_setting,
    output ready
  );
endinterface

/* hdl/led_matrix_serial_driver_core.sv */
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    mode, pin_level, data_bit, elapsed_cycles, query_row
// out_o     out  valid/ready    segment_drive, digit_select, scan_position,
//                               queried_pattern, register_written, brightness,
//                               decode_setting
// cfg       in   cfg_we_i       cfg_wdata_i -> scan slot length (cycles)
//
// One event at a time. Pin events and unused modes go through S_EXEC, S_READ
// and S_RESP to the output register; a tick adds S_DIV, where the 21-step
// bit-serial divider splits the accumulated cycle count into whole scan slots
// and a remainder. in_i.ready is high only while the sequencer is idle. A
// result sits in the output register; the next event is taken meanwhile and
// waits at the end of its work until out_o is free. Reset (async, active
// low) resets all control state, blanks the digit rows, shuts the chip down.
module led_matrix_serial_driver_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lmsd_pkg::SLOT_W-1:0] cfg_wdata_i,
  lmsd_in_if.sink                     in_i,
  lmsd_out_if.source                  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_READ,
    S_RESP
  } state_e;

  state_e state_q;

  // captured event
  logic [1:0]                        mode_q;
  logic                              pin_q;
  logic                              din_q;
  logic [lmsd_pkg::ELAPSED_W-1:0]    elapsed_q;
  logic [lmsd_pkg::DIG_AW-1:0]       qrow_q;

  // scan timing
  logic [lmsd_pkg::SLOT_W-1:0]       slot_q;
  logic [lmsd_pkg::SLOT_W-1:0]       acc_q;
  logic [lmsd_pkg::DIG_AW-1:0]       scan_q;

  // output register
  logic                              ovld_q;
  logic [lmsd_pkg::ROW_W-1:0]        seg_q;
  logic [lmsd_pkg::DIGITS-1:0]       sel_q;
  logic [lmsd_pkg::DIG_AW-1:0]       pos_q;
  logic [lmsd_pkg::ROW_W-1:0]        qpat_q;
  logic                              wr_q;
  logic [3:0]                        bright_q;
  logic [7:0]                        dec_q;

  logic                              in_xfer;
  logic                              out_free;
  logic                              div_start;
  logic                              div_done;
  logic [lmsd_pkg::DIG_AW-1:0]       div_qlo;
  logic [lmsd_pkg::SLOT_W-1:0]       div_rem;
  logic [lmsd_pkg::TOTAL_W-1:0]      total;
  logic [lmsd_pkg::SLOT_W-1:0]       slot_eff;
  logic [lmsd_pkg::ROW_W-1:0]        row_scan, row_query;
  logic                              written;
  lmsd_pkg::disp_cfg_t               disp;

  // visible pattern: blank when shut down or beyond scan limit, lit in test
  function automatic logic [lmsd_pkg::ROW_W-1:0] visible(
    input lmsd_pkg::disp_cfg_t         cfg,
    input logic [lmsd_pkg::DIG_AW-1:0] row,
    input logic [lmsd_pkg::ROW_W-1:0]  data
  );
    if (cfg.shutdown || (row > cfg.last_digit)) begin
      return '0;
    end
    return cfg.test ? '1 : data;
  endfunction

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !ovld_q || out_o.ready;

  // a zero slot length is taken as a slot length of 1
  assign slot_eff  = (slot_q == '0) ? lmsd_pkg::SLOT_W'(1) : slot_q;
  assign total     = {1'b0, acc_q} + lmsd_pkg::TOTAL_W'(elapsed_q);
  assign div_start = (state_q == S_EXEC) && (mode_q == lmsd_pkg::EV_TICK);

  lmsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total),
    .divisor_i  (slot_eff),
    .done_o     (div_done),
    .quot_lo_o  (div_qlo),
    .rem_o      (div_rem)
  );

  lmsd_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apply_i     (state_q == S_EXEC),
    .mode_i      (mode_q),
    .pin_level_i (pin_q),
    .data_bit_i  (din_q),
    .rd_addr_a_i (scan_q),
    .rd_addr_b_i (qrow_q),
    .rd_row_a_o  (row_scan),
    .rd_row_b_o  (row_query),
    .written_o   (written),
    .disp_o      (disp)
  );

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      slot_q   <= lmsd_pkg::SLOT_RESET;
      acc_q    <= '0;
      scan_q   <= '0;
      ovld_q   <= 1'b0;
      seg_q    <= '0;
      sel_q    <= '1;
      pos_q    <= '0;
      qpat_q   <= '0;
      wr_q     <= 1'b0;
      bright_q <= '0;
      dec_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        slot_q <= cfg_wdata_i;
      end
      // a result that moves on is replaced in the same cycle if the next one waits in S_RESP
      if ((state_q == S_RESP) && out_free) begin
        ovld_q   <= 1'b1;
        seg_q    <= visible(disp, scan_q, row_scan);
        sel_q    <= (!disp.shutdown && (scan_q <= disp.last_digit))
                    ? ~(lmsd_pkg::DIGITS'(1) << scan_q) : '1;
        pos_q    <= scan_q;
        qpat_q   <= visible(disp, qrow_q, row_query);
        wr_q     <= written;
        bright_q <= disp.intensity;
        dec_q    <= disp.decode;
      end else if (out_o.ready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= (mode_q == lmsd_pkg::EV_TICK) ? S_DIV : S_READ;
        end
        S_DIV: begin
          if (div_done) begin
            acc_q   <= div_rem;
            scan_q  <= scan_q + div_qlo;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          // row RAM address set up here, data valid next cycle
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // captured event fields
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mode_q    <= in_i.mode;
      pin_q     <= in_i.pin_level;
      din_q     <= in_i.data_bit;
      elapsed_q <= in_i.elapsed_cycles;
      qrow_q    <= in_i.query_row;
    end
  end

  assign out_o.valid            = ovld_q;
  assign out_o.segment_drive    = seg_q;
  assign out_o.digit_select     = sel_q;
  assign out_o.scan_position    = pos_q;
  assign out_o.queried_pattern  = qpat_q;
  assign out_o.register_written = wr_q;
  assign out_o.brightness       = bright_q;
  assign out_o.decode_setting   = dec_q;

endmodule

/* hdl/lmsd_ram.sv */
module lmsd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

/* hdl/lmsd_div.sv */
// Restoring divider, one quotient bit per cycle. Only the low quotient
// bits are kept (scan position wraps modulo the digit count).
module lmsd_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lmsd_pkg::TOTAL_W-1:0]        dividend_i,
  input  logic [lmsd_pkg::SLOT_W-1:0]         divisor_i,
  output logic                                done_o,
  output logic [lmsd_pkg::DIG_AW-1:0]         quot_lo_o,
  output logic [lmsd_pkg::SLOT_W-1:0]         rem_o
);

  localparam int unsigned STEP_W = $clog2(lmsd_pkg::TOTAL_W);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic [STEP_W-1:0]                 cnt_q, cnt_d;
  logic [lmsd_pkg::TOTAL_W-1:0]      rem_q, rem_d;
  logic [lmsd_pkg::TOTAL_W-1:0]      dvd_q, dvd_d;
  logic [lmsd_pkg::SLOT_W-1:0]       dvs_q, dvs_d;
  logic [lmsd_pkg::DIG_AW-1:0]       qlo_q, qlo_d;
  logic [lmsd_pkg::TOTAL_W-1:0]      trial;
  logic                              fits;

  // partial remainder stays below the divisor, so its top bit is always 0
  assign trial = {rem_q[lmsd_pkg::TOTAL_W-2:0], dvd_q[lmsd_pkg::TOTAL_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    qlo_d  = qlo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(lmsd_pkg::TOTAL_W - 1);
      rem_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      qlo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      dvd_d = {dvd_q[lmsd_pkg::TOTAL_W-2:0], 1'b0};
      qlo_d = {qlo_q[lmsd_pkg::DIG_AW-2:0], fits};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    qlo_q <= qlo_d;
  end

  assign done_o    = done_q;
  assign quot_lo_o = qlo_q;
  assign rem_o     = rem_q[lmsd_pkg::SLOT_W-1:0];

endmodule

/* hdl/lmsd_regs.sv */
// Serial shifter, pin edge tracking and the chip's register file.
// Digit rows live in a small RAM with per-row valid bits (row reads 0 until
// first written). Reads are registered and return in the cycle after the address.
module lmsd_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              apply_i,
  input  logic [1:0]                        mode_i,
  input  logic                              pin_level_i,
  input  logic                              data_bit_i,
  input  logic [lmsd_pkg::DIG_AW-1:0]       rd_addr_a_i,
  input  logic [lmsd_pkg::DIG_AW-1:0]       rd_addr_b_i,
  output logic [lmsd_pkg::ROW_W-1:0]        rd_row_a_o,
  output logic [lmsd_pkg::ROW_W-1:0]        rd_row_b_o,
  output logic                              written_o,
  output lmsd_pkg::disp_cfg_t               disp_o
);

  logic [lmsd_pkg::WORD_BITS-1:0]  shift_q;
  logic [lmsd_pkg::BITCNT_W-1:0]   bits_q;
  logic                            clk_seen_q;
  logic                            load_seen_q;
  logic                            written_q;
  lmsd_pkg::disp_cfg_t             disp_q;
  logic [lmsd_pkg::DIGITS-1:0]     row_vld_q;
  logic                            vld_a_q, vld_b_q;

  logic [7:0]                      addr;
  logic [7:0]                      val;
  logic                            latch;
  logic                            row_we;
  logic [lmsd_pkg::DIG_AW-1:0]     row_waddr;
  logic [lmsd_pkg::ROW_W-1:0]      ram_a, ram_b;

  assign addr  = shift_q[15:8];
  assign val   = shift_q[7:0];
  assign latch = apply_i && (mode_i == lmsd_pkg::EV_LOAD) && pin_level_i && !load_seen_q
                 && (bits_q == lmsd_pkg::BITCNT_W'(lmsd_pkg::WORD_BITS));
  assign row_we    = latch && (addr >= lmsd_pkg::ADDR_DIGIT_LO)
                     && (addr <= lmsd_pkg::ADDR_DIGIT_HI);
  assign row_waddr = lmsd_pkg::DIG_AW'(addr - lmsd_pkg::ADDR_DIGIT_LO);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bits_q      <= '0;
      clk_seen_q  <= 1'b0;
      load_seen_q <= 1'b1;
      written_q   <= 1'b0;
      disp_q      <= '{decode: '0, intensity: '0, last_digit: '1,
                       shutdown: 1'b1, test: 1'b0};
      row_vld_q   <= '0;
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
    end else begin
      vld_a_q <= row_vld_q[rd_addr_a_i];
      vld_b_q <= row_vld_q[rd_addr_b_i];
      if (apply_i) begin
        written_q <= latch;
        case (mode_i)
          lmsd_pkg::EV_CLOCK: begin
            if (!load_seen_q && pin_level_i && !clk_seen_q) begin
              shift_q <= {shift_q[lmsd_pkg::WORD_BITS-2:0], data_bit_i};
              if (bits_q != lmsd_pkg::BITCNT_W'(lmsd_pkg::WORD_BITS)) begin
                bits_q <= bits_q + lmsd_pkg::BITCNT_W'(1);
              end
            end
            clk_seen_q <= pin_level_i;
          end
          lmsd_pkg::EV_LOAD: begin
            if (latch) begin
              case (addr)
                lmsd_pkg::ADDR_DECODE:    disp_q.decode     <= val;
                lmsd_pkg::ADDR_INTENSITY: disp_q.intensity  <= val[3:0];
                lmsd_pkg::ADDR_SCAN_LIM:  disp_q.last_digit <= val[lmsd_pkg::DIG_AW-1:0];
                lmsd_pkg::ADDR_SHUTDOWN:  disp_q.shutdown   <= !val[0];
                lmsd_pkg::ADDR_TEST:      disp_q.test       <= val[0];
                default: ;
              endcase
            end
            if (row_we) begin
              row_vld_q[row_waddr] <= 1'b1;
            end
            if (!pin_level_i && load_seen_q) begin
              shift_q <= '0;
              bits_q  <= '0;
            end
            load_seen_q <= pin_level_i;
          end
          default: ;
        endcase
      end
    end
  end

  lmsd_ram #(
    .WIDTH (lmsd_pkg::ROW_W),
    .DEPTH (lmsd_pkg::DIGITS)
  ) u_rows (
    .clk_i     (clk_i),
    .we_i      (row_we),
    .waddr_i   (row_waddr),
    .wdata_i   (val),
    .raddr_a_i (rd_addr_a_i),
    .rdata_a_o (ram_a),
    .raddr_b_i (rd_addr_b_i),
    .rdata_b_o (ram_b)
  );

  assign rd_row_a_o = vld_a_q ? ram_a : '0;
  assign rd_row_b_o = vld_b_q ? ram_b : '0;
  assign written_o  = written_q;
  assign disp_o     = disp_q;

endmodule
